### rtl/core/pal_pkg.sv
// Shared types and codes for the positional array list unit.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } pal_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        logic [POS_W-1:0]    found_position;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    item_count;
    } pal_res_t;

endpackage

`default_nettype wire

### rtl/core/pal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pal_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/core/pal_seq.sv
// Operation sequencer: range checks, entry walk over the RAM, shared compare.
`timescale 1ns / 1ps
`default_nettype none

module pal_seq import pal_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int ADDR_W      = $clog2(DEPTH)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire pal_req_t               req,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output pal_res_t                    res,
    output logic                        mem_wr_en,
    output logic      [ADDR_W-1:0]      mem_wr_addr,
    output logic      [VALUE_WIDTH-1:0] mem_wr_data,
    output logic      [ADDR_W-1:0]      mem_rd_addr,
    input  wire logic [VALUE_WIDTH-1:0] mem_rd_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [ADDR_W-1:0]      k_reg, k_next;
    logic [ADDR_W-1:0]      pos_idx_reg, pos_idx_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [VALUE_WIDTH-1:0] rd_reg, rd_next;
    logic [POS_W-1:0]       found_reg, found_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   first_reg, first_next;

    logic [PW-1:0]          p_ext;
    logic [PW-1:0]          c_ext;
    logic [ADDR_W-1:0]      pos_m1;
    logic [ADDR_W-1:0]      cnt_m1;
    logic [CW-1:0]          kp1;
    logic                   hit;
    logic [63:0]            rd_wide;

    assign p_ext   = PW'(req.position);
    assign c_ext   = PW'(cnt_reg);
    assign pos_m1  = ADDR_W'(req.position - POS_W'(1));
    assign cnt_m1  = ADDR_W'(cnt_reg - CW'(1));
    assign kp1     = CW'(k_reg) + CW'(1);
    assign hit     = (mem_rd_data == val_reg);
    assign rd_wide = 64'(rd_reg);

    assign req_ready   = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign mem_rd_addr = k_reg;

    assign res.read_value     = rd_wide[DATA_W-1:0];
    assign res.found_position = found_reg;
    assign res.status         = status_reg;
    assign res.item_count     = POS_W'(cnt_reg);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        pos_idx_next = pos_idx_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        rd_next      = rd_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        first_next   = first_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = k_reg;
        mem_wr_data  = mem_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req.operation;
                    val_next     = VALUE_WIDTH'(req.value);
                    pos_idx_next = pos_m1;
                    rd_next      = '0;
                    found_next   = '0;
                    first_next   = 1'b1;
                    status_next  = ST_OK;
                    state_next   = S_DONE;
                    case (req.operation)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else if (p_ext == '0 || p_ext > c_ext + PW'(1))
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (p_ext == c_ext + PW'(1))
                            begin
                                // append: nothing to shift
                                state_next = S_FIN;
                            end
                            else
                            begin
                                k_next     = cnt_m1;
                                state_next = S_RD;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else if (p_ext == '0 || p_ext > c_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                k_next     = pos_m1;
                                state_next = S_RD;
                            end
                        end
                        OP_GET:
                        begin
                            if (p_ext == '0 || p_ext > c_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                k_next     = pos_m1;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg != '0)
                            begin
                                k_next     = '0;
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_WR;
            end

            S_WR:
            begin
                case (op_reg)
                    OP_GET:
                    begin
                        rd_next    = mem_rd_data;
                        state_next = S_DONE;
                    end
                    OP_DELETE:
                    begin
                        // first read is the removed entry, later reads move down one
                        if (first_reg)
                        begin
                            rd_next = mem_rd_data;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = k_reg - ADDR_W'(1);
                        end
                        first_next = 1'b0;
                        if (kp1 < cnt_reg)
                        begin
                            k_next     = k_reg + ADDR_W'(1);
                            state_next = S_RD;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = S_DONE;
                        end
                    end
                    OP_INSERT:
                    begin
                        // walk down from the tail, moving each entry up one
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = k_reg + ADDR_W'(1);
                        if (k_reg == pos_idx_reg)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            k_next     = k_reg - ADDR_W'(1);
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        if (hit)
                        begin
                            found_next = POS_W'(kp1);
                            state_next = S_DONE;
                        end
                        else if (kp1 < cnt_reg)
                        begin
                            k_next     = k_reg + ADDR_W'(1);
                            state_next = S_RD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                endcase
            end

            S_FIN:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_idx_reg;
                mem_wr_data = val_reg;
                cnt_next    = cnt_reg + CW'(1);
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        pos_idx_reg <= pos_idx_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        rd_reg      <= rd_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        first_reg   <= first_next;
    end

endmodule

`default_nettype wire

### rtl/core/positional_array_list_unit.sv
// Positional array list: ordered list of up to DEPTH values in one RAM.
//
// Input channel (in_valid/in_ready) carries operation, position, value; one
// beat per operation: insert, delete, get by position, locate value.
// Output channel (out_valid/out_ready) returns one beat per input beat:
// read_value, found_position, status and item_count after the operation.
// One operation is in flight at a time; in_ready is high only while the
// sequencer is idle. Each entry visited takes a RAM read state, then a
// write or compare state on the single RAM port pair:
//   get             : reads the entry at the position
//   insert at pos p : shifts entries p..count up from the tail, writes value
//   delete at pos p : reads entry p, then moves later entries down one
//   locate          : walks from entry 1 to the first match or the end
//   any error       : goes straight to the result
// Results are then registered at the output. A finished result sits in the
// output register; the next beat is taken while it waits, and the sequencer
// holds its own result if the output register is still occupied.
// Reset empties the list (count to zero); RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list_unit import pal_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [POS_W-1:0]    position,
    input  wire logic [DATA_W-1:0]   value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [DATA_W-1:0]   read_value,
    output logic      [POS_W-1:0]    found_position,
    output logic      [STATUS_W-1:0] status,
    output logic      [POS_W-1:0]    item_count
);

    localparam int ADDR_W = $clog2(DEPTH);

    pal_req_t               req;
    pal_res_t               res;
    logic                   res_valid;
    logic                   res_ready;
    logic                   mem_wr_en;
    logic [ADDR_W-1:0]      mem_wr_addr;
    logic [VALUE_WIDTH-1:0] mem_wr_data;
    logic [ADDR_W-1:0]      mem_rd_addr;
    logic [VALUE_WIDTH-1:0] mem_rd_data;

    logic                   out_valid_reg;
    pal_res_t               out_reg;

    assign req.operation = operation;
    assign req.position  = position;
    assign req.value     = value;

    pal_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (in_valid),
        .req_ready   (in_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    pal_ram #(
        .WIDTH  (VALUE_WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_entry_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register: refill when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_value     = out_reg.read_value;
    assign found_position = out_reg.found_position;
    assign status         = out_reg.status;
    assign item_count     = out_reg.item_count;

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for positional_array_list_unit: directed edge cases, output stall and random list traffic.
`timescale 1ns / 1ps

module testbench;
    import pal_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 150;
    localparam int RANDOM_ITEMS = 1450;
    localparam int QUIET_TAIL   = 200;
    localparam int MODE_GROW    = 0;
    localparam int MODE_MIXED   = 1;
    localparam int MODE_SHRINK  = 2;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     operation;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   value;
    logic                out_valid;
    logic                out_ready;
    logic [DATA_W-1:0]   read_value;
    logic [POS_W-1:0]    found_position;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    item_count;

    // list as the testbench sees it
    logic [DATA_W-1:0] list_mem [LIST_DEPTH];
    int                list_len;
    pal_res_t          predicted_results[$];

    int  err_count;
    int  ops_sent;
    int  results_checked;
    int  peak_len;
    int  status_seen [4];
    int  cycle_count;
    bit  quiet;
    bit  long_hold_req;

    positional_array_list_unit #(
        .DEPTH       (LIST_DEPTH),
        .VALUE_WIDTH (DATA_W)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .found_position (found_position),
        .status         (status),
        .item_count     (item_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, predicted_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Applies one operation to the tracked list and returns the result it should give.
    function automatic pal_res_t list_apply(input logic [OP_W-1:0] op,
                                            input logic [POS_W-1:0] pos,
                                            input logic [DATA_W-1:0] val);
        pal_res_t res;
        int       p;
        res = '0;
        res.status = ST_OK;
        p = int'(pos);
        case (op)
            OP_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                    res.status = ST_OVERFLOW;
                else if (p < 1 || p > list_len + 1)
                    res.status = ST_BADPOS;
                else
                begin
                    for (int k = list_len; k >= p; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[p-1] = val;
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                if (list_len == 0)
                    res.status = ST_UNDERFLOW;
                else if (p < 1 || p > list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    res.read_value = list_mem[p-1];
                    for (int k = p; k < list_len; k++)
                        list_mem[k-1] = list_mem[k];
                    list_len--;
                end
            end
            OP_GET:
            begin
                if (p < 1 || p > list_len)
                    res.status = ST_BADPOS;
                else
                    res.read_value = list_mem[p-1];
            end
            default:
            begin
                for (int k = 0; k < list_len; k++)
                begin
                    if (list_mem[k] == val)
                    begin
                        res.found_position = POS_W'(k + 1);
                        break;
                    end
                end
            end
        endcase
        res.item_count = POS_W'(list_len);
        status_seen[res.status]++;
        if (list_len > peak_len)
            peak_len = list_len;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] common_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            4: return 32'hA5A5_A5A5;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // Offers one beat, holding it until accepted; valid stays up for a back-to-back beat.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        position  <= pos;
        value     <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted_results.push_back(list_apply(op, pos, val));
        ops_sent++;
    endtask

    task automatic send_random(input int mode);
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        int                roll;
        int                top;
        int                ins_cut;
        int                del_cut;
        int                get_cut;
        if ($urandom_range(0, 99) < 8)
        begin
            // noise: anything the fields allow
            op  = OP_W'($urandom_range(0, 3));
            pos = POS_W'($urandom_range(0, 127));
            val = $urandom();
        end
        else
        begin
            case (mode)
                MODE_GROW:
                begin
                    ins_cut = 70;
                    del_cut = 80;
                    get_cut = 90;
                end
                MODE_SHRINK:
                begin
                    ins_cut = 15;
                    del_cut = 75;
                    get_cut = 90;
                end
                default:
                begin
                    ins_cut = 35;
                    del_cut = 65;
                    get_cut = 80;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_cut)
                op = OP_INSERT;
            else if (roll < del_cut)
                op = OP_DELETE;
            else if (roll < get_cut)
                op = OP_GET;
            else
                op = OP_LOCATE;

            top = (op == OP_INSERT) ? list_len + 1 : list_len;
            if (top < 1 || $urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: pos = '0;
                    1: pos = POS_W'(top + 1);
                    default: pos = POS_W'($urandom_range(top + 1, 127));
                endcase
            end
            else
            begin
                // favor the two ends of the list
                case ($urandom_range(0, 3))
                    0: pos = POS_W'(1);
                    1: pos = POS_W'(top);
                    default: pos = POS_W'($urandom_range(1, top));
                endcase
            end

            roll = $urandom_range(0, 99);
            if (op == OP_INSERT)
                val = (roll < 30) ? common_value() : $urandom();
            else if (op == OP_LOCATE && roll < 40 && list_len > 0)
                val = list_mem[$urandom_range(0, list_len - 1)];
            else if (op == OP_LOCATE && roll < 70)
                val = common_value();
            else
                val = $urandom();
        end
        send_op(op, pos, val);
    endtask

    task automatic compare_field(input string field, input logic [DATA_W-1:0] want_val,
                                 input logic [DATA_W-1:0] got_val);
        if (got_val !== want_val)
        begin
            $display("%0t ns: %s mismatch: expected %0h, actual %0h",
                     $time, field, want_val, got_val);
            err_count++;
        end
    endtask

    // Result side: random stalls, one long hold on request, and the check of each beat.
    initial
    begin : result_monitor
        int       hold_left;
        pal_res_t want;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t ns: result beat with none expected: value %0h pos %0d st %0d",
                             $time, read_value, found_position, status);
                    err_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("read_value", want.read_value, read_value);
                    compare_field("found_position", DATA_W'(want.found_position),
                                  DATA_W'(found_position));
                    compare_field("status", DATA_W'(want.status), DATA_W'(status));
                    compare_field("item_count", DATA_W'(want.item_count), DATA_W'(item_count));
                    results_checked++;
                end
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 400;
            end
            else if (hold_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 14);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic test_empty_list_errors();
        send_op(OP_DELETE, 7'd1, 32'h1111_1111);
        send_op(OP_DELETE, 7'd0, 32'h0);
        send_op(OP_GET, 7'd1, 32'h0);
        send_op(OP_GET, 7'd0, 32'hFFFF_FFFF);
        send_op(OP_LOCATE, 7'd0, 32'h0);
        send_op(OP_INSERT, 7'd0, 32'h2222_2222);
        send_op(OP_INSERT, 7'd2, 32'h3333_3333);
    endtask

    task automatic test_directed_edits();
        send_op(OP_INSERT, 7'd1, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 7'd1, 32'h0000_0000);
        send_op(OP_INSERT, 7'd3, 32'h8000_0001);
        // duplicate in the middle: locate must report the first one
        send_op(OP_INSERT, 7'd2, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 7'd127, 32'h0000_0001);
        send_op(OP_INSERT, 7'd6, 32'h0000_0001);
        send_op(OP_LOCATE, 7'd127, 32'hFFFF_FFFF);
        send_op(OP_LOCATE, 7'd0, 32'h0000_0000);
        send_op(OP_LOCATE, 7'd1, 32'h1234_5678);
        send_op(OP_GET, 7'd4, 32'h0);
        send_op(OP_GET, 7'd5, 32'h0);
        send_op(OP_GET, 7'd127, 32'h0);
        send_op(OP_DELETE, 7'd5, 32'h0);
        send_op(OP_DELETE, 7'd0, 32'h0);
        send_op(OP_DELETE, 7'd4, 32'h0);
        send_op(OP_DELETE, 7'd1, 32'h0);
        send_op(OP_GET, 7'd1, 32'h0);
    endtask

    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            send_random(MODE_MIXED);
    endtask

    task automatic test_random_mix();
        int phase;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // grow to full, churn, drain to empty, churn again
            phase = (i / 150) % 4;
            if (i >= RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            if (phase == 0)
                send_random(MODE_GROW);
            else if (phase == 2)
                send_random(MODE_SHRINK);
            else
                send_random(MODE_MIXED);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        operation <= OP_INSERT;
        position  <= '0;
        value     <= '0;
        list_len  = 0;
        quiet     = 1'b0;
        long_hold_req = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list_errors();
        test_directed_edits();
        test_output_backpressure();
        test_random_mix();
        wait_for_results();

        $display("Covered %0d operations, %0d results checked; the list peaked at %0d of %0d.",
                 ops_sent, results_checked, peak_len, LIST_DEPTH);
        $display("Errors exercised: %0d overflow, %0d bad position, %0d underflow; %0d cycles.",
                 status_seen[ST_OVERFLOW], status_seen[ST_BADPOS], status_seen[ST_UNDERFLOW],
                 cycle_count);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/core/pal_pkg.sv
rtl/core/pal_ram.sv
rtl/core/pal_seq.sv
rtl/core/positional_array_list_unit.sv
verif/testbench.sv
